>>> hw/rtl/ihp_pkg.sv
`default_nettype none

package ihp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned NumW   = 31;
  localparam int unsigned CapW   = 7;

  localparam logic [CapW-1:0]  CapReset  = 7'd32;
  localparam logic [NumW-1:0]  NumMax    = 31'h7FFF_FFFF;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;
  localparam logic [CharW-1:0] CharBlank = 8'h20;
  localparam logic [CharW-1:0] CharLf    = 8'h0A;
  localparam logic [CharW-1:0] CharCr    = 8'h0D;

  // One-hot parse phases.
  typedef enum logic [3:0] {
    PhType  = 4'b0001,
    PhDepth = 4'b0010,
    PhCount = 4'b0100,
    PhDone  = 4'b1000
  } ihp_phase_e;

  // One input character with its end-of-text marker.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } ihp_item_t;

  // One result item.
  typedef struct packed {
    logic             type_char_valid;
    logic [CharW-1:0] type_char;
    logic             verdict_valid;
    logic             header_ok;
    logic [NumW-1:0]  depth_value;
    logic [NumW-1:0]  count_value;
  } ihp_result_t;

  // acc * 10 + digit, saturated at the largest 31-bit value.
  function automatic logic [NumW-1:0] acc_dec(logic [NumW-1:0] acc, logic [3:0] dig);
    logic [NumW+3:0] wide;
    wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {{NumW{1'b0}}, dig};
    return (wide > {4'b0000, NumMax}) ? NumMax : wide[NumW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ihp_in_reg.sv
`default_nettype none

module ihp_in_reg
  import ihp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ihp_item_t in_item_i,
  output logic           item_valid_o,
  input  wire logic      item_take_i,
  output ihp_item_t      item_o
);

  logic      valid_q, valid_d;
  ihp_item_t item_q;

  // The register may refill in the same cycle that the parser takes it.
  assign in_ready_o = !valid_q || item_take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !item_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

>>> hw/rtl/ihp_parse.sv
`default_nettype none

module ihp_parse
  import ihp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CapW-1:0] cfg_data_i,
  input  wire logic            item_valid_i,
  output logic                 item_take_o,
  input  wire ihp_item_t       item_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output ihp_result_t          res_o
);

  ihp_phase_e      phase_q, phase_d;
  logic [CapW-1:0] cap_q;
  logic [CapW-1:0] kept_q, kept_d;
  logic [NumW-1:0] depth_q, depth_d;
  logic [NumW-1:0] count_q, count_d;
  logic            seen_q, seen_d;
  logic            out_valid_q;
  ihp_result_t     res_q, res_d;

  logic is_digit;
  logic tcv, vv, ok;

  assign item_take_o = item_valid_i && (!out_valid_q || res_ready_i);
  assign is_digit    = (item_i.ch >= CharZero) && (item_i.ch <= CharNine);

  always_comb begin
    phase_d = phase_q;
    kept_d  = kept_q;
    depth_d = depth_q;
    count_d = count_q;
    seen_d  = seen_q;
    tcv     = 1'b0;
    vv      = 1'b0;
    ok      = 1'b0;
    if (item_i.last) begin
      vv      = (phase_q != PhDone);
      ok      = (phase_q == PhCount) && seen_q;
      phase_d = PhType;
      kept_d  = '0;
      depth_d = '0;
      count_d = '0;
      seen_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PhType: begin
          if (item_i.ch == CharBlank) begin
            if (kept_q == '0) begin
              vv      = 1'b1;
              phase_d = PhDone;
            end else begin
              phase_d = PhDepth;
              seen_d  = 1'b0;
            end
          end else if (item_i.ch == CharLf) begin
            vv      = 1'b1;
            phase_d = PhDone;
          end else if (({1'b0, kept_q} + 8'd1) < {1'b0, cap_q}) begin
            tcv    = 1'b1;
            kept_d = kept_q + 7'd1;
          end
        end
        PhDepth: begin
          if (is_digit) begin
            depth_d = acc_dec(depth_q, item_i.ch[3:0]);
            seen_d  = 1'b1;
          end else if ((item_i.ch == CharBlank) && seen_q) begin
            phase_d = PhCount;
            seen_d  = 1'b0;
          end else begin
            vv      = 1'b1;
            phase_d = PhDone;
          end
        end
        PhCount: begin
          if (is_digit) begin
            count_d = acc_dec(count_q, item_i.ch[3:0]);
            seen_d  = 1'b1;
          end else begin
            vv      = 1'b1;
            ok      = ((item_i.ch == CharLf) || (item_i.ch == CharCr)) && seen_q;
            phase_d = PhDone;
          end
        end
        PhDone: begin
        end
        default: begin
          phase_d = PhDone;
        end
      endcase
    end

    res_d.type_char_valid = tcv;
    res_d.type_char       = tcv ? item_i.ch : '0;
    res_d.verdict_valid   = vv;
    res_d.header_ok       = ok;
    res_d.depth_value     = ok ? depth_q : '0;
    res_d.count_value     = ok ? count_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhType;
      kept_q      <= '0;
      depth_q     <= '0;
      count_q     <= '0;
      seen_q      <= 1'b0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (item_take_o) begin
        phase_q <= phase_d;
        kept_q  <= kept_d;
        depth_q <= depth_d;
        count_q <= count_d;
        seen_q  <= seen_d;
      end
      if (item_take_o) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // An end marker always leaves the parser in its cleared state.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && item_i.last |=> phase_q == PhType && kept_q == '0 &&
      depth_q == '0 && count_q == '0 && !seen_q)
    else $error("end marker did not clear the parser");

  // A type character and a verdict never share one result.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.type_char_valid && res_q.verdict_valid))
    else $error("type character and verdict in one result");

  // Numbers appear only with a good verdict.
  a_ok_vals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.header_ok |-> res_q.depth_value == '0 &&
      res_q.count_value == '0)
    else $error("numbers shown without a good verdict");

  a_ok_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.header_ok |-> res_q.verdict_valid)
    else $error("header_ok without verdict_valid");

endmodule

`default_nettype wire

>>> hw/rtl/inspect_header_parser_top.sv
// Header parser for lines of the form "type depth count".
//
// Input stream: one character per request on s_axis_tdata, with s_axis_tlast
// marking the terminating end of the text (its character is ignored).
// Output stream: exactly one result request for every input request, in
// order. m_axis_tuser says what the result carries: a kept type character,
// a verdict, or neither (an ignored character).
// Configuration: cfg_data_i is the type buffer capacity, written when
// cfg_valid_i is high; cfg_ready_o is always high. Write it only while no
// character is in flight.
//
// From acceptance to m_axis_tvalid the character sits in the input register
// while the parse logic works on it, and then its result is loaded into the
// result register. Throughput is one character per cycle while the receiver
// does not stall; the parse state and the decimal multiply-by-ten accumulate
// are combinational. Reset clears the parse state, empties both registers and
// sets the capacity to 32. When the receiver stalls, the result is held and
// the input register takes one more character, after which s_axis_tready
// falls until the stall clears; nothing is lost or repeated.
`default_nettype none

module inspect_header_parser_top
  import ihp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [7:0] type_char, [8] header_ok,
                                           // [39:9] depth_value,
                                           // [70:40] count_value, [71] zero
  output logic [1:0]       m_axis_tuser,   // [0] type_char_valid,
                                           // [1] verdict_valid
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);

  ihp_item_t   in_item;
  ihp_item_t   item;
  logic        item_valid;
  logic        item_take;
  ihp_result_t res;

  assign in_item.ch   = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // The capacity register has no back-pressure.
  assign cfg_ready_o = 1'b1;

  ihp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  ihp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {1'b0, res.count_value, res.depth_value, res.header_ok,
                         res.type_char};
  assign m_axis_tuser = {res.verdict_valid, res.type_char_valid};

endmodule

`default_nettype wire
